// File: hw/rtl/scan_peak_valley_detector_macros.svh
// Assertion macros for the scan peak and valley detector.
// Every use needs a clock named clk and a reset named rst in scope.
`ifndef SCAN_PEAK_VALLEY_DETECTOR_MACROS_SVH
`define SCAN_PEAK_VALLEY_DETECTOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SPVD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SPVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/spvd_pkg.sv
// Shared types and constants of the scan peak and valley detector.
// No dependencies.
package spvd_pkg;

  localparam logic [1:0] REG_MAX_DISTANCE  = 2'd0;
  localparam logic [1:0] REG_GUARD_SAMPLES = 2'd1;
  localparam logic [1:0] REG_CONFIRM_STEPS = 2'd2;

  localparam logic [14:0] MAX_DISTANCE_RESET  = 15'd345;
  localparam logic [7:0]  GUARD_SAMPLES_RESET = 8'd5;
  localparam logic [3:0]  CONFIRM_STEPS_RESET = 4'd2;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_PEAK   = 2'd1;
  localparam logic [1:0] EV_VALLEY = 2'd2;

  typedef struct packed {
    logic [14:0] max_distance;
    logic [7:0]  guard_samples;
    logic [3:0]  confirm_steps;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] filtered_sample;
    logic [1:0]         event_res;
    logic signed [15:0] extreme_value;
    logic [7:0]         extreme_index;
    logic [3:0]         peak_total;
    logic [3:0]         valley_total;
  } result_t;

endpackage

// File: hw/rtl/scan_peak_valley_detector.sv
// Scan peak and valley detector, top level.
// An accepted word is held in the input register, then moves on to the result register
// when the output can take it. Throughput: one word per cycle unless the output stalls;
// the input register and the result register each hold one word, and all filtering and
// slope logic lies between them. Reset: synchronous; clears all scan state and restores the register defaults.
// Depends on spvd_pkg, spvd_cfg, spvd_core and the assertion macro header.
`include "scan_peak_valley_detector_macros.svh"

module scan_peak_valley_detector #(
  parameter int SCAN_LENGTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               scan_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] filtered_sample,
  output logic [1:0]         event_res,
  output logic signed [15:0] extreme_value,
  output logic [7:0]         extreme_index,
  output logic [3:0]         peak_total,
  output logic [3:0]         valley_total
);
  import spvd_pkg::*;

  cfg_t               cfg;
  logic               in_full;
  logic signed [15:0] held_sample;
  logic               held_start;
  logic               step;
  result_t            core_res;
  result_t            out_word;

  assign cfg_ready = 1'b1;
  assign step      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || step;

  spvd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  spvd_core #(
    .SCAN_LENGTH (SCAN_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .sample     (held_sample),
    .scan_start (held_start),
    .cfg        (cfg),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      held_sample <= sample;
      held_start  <= scan_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      out_word <= core_res;
    end
  end

  assign filtered_sample = out_word.filtered_sample;
  assign event_res       = out_word.event_res;
  assign extreme_value   = out_word.extreme_value;
  assign extreme_index   = out_word.extreme_index;
  assign peak_total      = out_word.peak_total;
  assign valley_total    = out_word.valley_total;

  `SPVD_ASSERT_SAME(a_peak_counted, out_valid && (event_res == EV_PEAK), peak_total != 4'd0, "peak without count")
  `SPVD_ASSERT_SAME(a_valley_counted, out_valid && (event_res == EV_VALLEY), valley_total != 4'd0, "valley without count")
  `SPVD_ASSERT_SAME(a_quiet_extreme, out_valid && (event_res == EV_NONE), (extreme_value == 16'sd0) && (extreme_index == 8'd0), "extreme fields set without event")
  `SPVD_ASSERT_NEXT(a_step_fills_output, step, out_valid, "processed word not presented")

endmodule

// File: hw/rtl/spvd_cfg.sv
// Configuration registers of the scan peak and valley detector.
// Depends on spvd_pkg.
module spvd_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [14:0]        wr_data,
  output spvd_pkg::cfg_t     cfg
);
  import spvd_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_distance  <= MAX_DISTANCE_RESET;
      regs.guard_samples <= GUARD_SAMPLES_RESET;
      regs.confirm_steps <= CONFIRM_STEPS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_DISTANCE:  regs.max_distance  <= wr_data;
        REG_GUARD_SAMPLES: regs.guard_samples <= wr_data[7:0];
        REG_CONFIRM_STEPS: regs.confirm_steps <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hw/rtl/spvd_core.sv
// Filter, slope tracking and peak and valley confirmation for one word.
// Depends on spvd_pkg.
module spvd_core #(
  parameter int SCAN_LENGTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic signed [15:0]  sample,
  input  logic                scan_start,
  input  spvd_pkg::cfg_t      cfg,
  output spvd_pkg::result_t   res
);
  import spvd_pkg::*;

  localparam int CNT_W = $clog2(SCAN_LENGTH + 1);

  typedef enum logic [1:0] {RUN_NONE, RUN_RISE, RUN_FALL} run_t;

  logic signed [15:0] previous_sample, previous_sample_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  run_t               run_mode, run_mode_next;
  logic               peak_pending, peak_pending_next;
  logic               valley_pending, valley_pending_next;
  logic [3:0]         fall_steps, fall_steps_next;
  logic [3:0]         rise_steps, rise_steps_next;
  logic signed [15:0] peak_cand_value, peak_cand_value_next;
  logic [7:0]         peak_cand_index, peak_cand_index_next;
  logic signed [15:0] valley_cand_value, valley_cand_value_next;
  logic [7:0]         valley_cand_index, valley_cand_index_next;
  logic [3:0]         peak_count, peak_count_next;
  logic [3:0]         valley_count, valley_count_next;

  logic [CNT_W+7:0]   k_ext;
  logic signed [15:0] f;
  logic [1:0]         ev;
  logic signed [15:0] xval;
  logic [7:0]         xidx;

  // A start-of-scan word sees cleared state; the nexts start from that view.
  always_comb begin
    previous_sample_next   = scan_start ? '0 : previous_sample;
    sample_count_next      = scan_start ? '0 : sample_count;
    run_mode_next          = scan_start ? RUN_NONE : run_mode;
    peak_pending_next      = scan_start ? 1'b0 : peak_pending;
    valley_pending_next    = scan_start ? 1'b0 : valley_pending;
    fall_steps_next        = scan_start ? '0 : fall_steps;
    rise_steps_next        = scan_start ? '0 : rise_steps;
    peak_cand_value_next   = scan_start ? '0 : peak_cand_value;
    peak_cand_index_next   = scan_start ? '0 : peak_cand_index;
    valley_cand_value_next = scan_start ? '0 : valley_cand_value;
    valley_cand_index_next = scan_start ? '0 : valley_cand_index;
    peak_count_next        = scan_start ? '0 : peak_count;
    valley_count_next      = scan_start ? '0 : valley_count;

    k_ext = {8'b0, sample_count_next};
    f     = sample;
    if ((k_ext > {{CNT_W{1'b0}}, cfg.guard_samples}) &&
        (sample[15] || (sample[14:0] > cfg.max_distance))) begin
      f = previous_sample_next;
    end

    ev   = EV_NONE;
    xval = '0;
    xidx = '0;

    if (sample_count_next < CNT_W'(SCAN_LENGTH)) begin
      if (sample_count_next != '0) begin
        if ((run_mode_next == RUN_RISE) && (f < previous_sample_next)) begin
          if (!valley_pending_next) begin
            peak_cand_value_next = previous_sample_next;
            peak_cand_index_next = k_ext[7:0] - 8'd1;
            peak_pending_next    = 1'b1;
          end else begin
            peak_pending_next = 1'b0;
          end
          fall_steps_next = '0;
          run_mode_next   = RUN_FALL;
        end else if ((run_mode_next == RUN_FALL) && (f > previous_sample_next)) begin
          if (!peak_pending_next) begin
            valley_cand_value_next = previous_sample_next;
            valley_cand_index_next = k_ext[7:0] - 8'd1;
            valley_pending_next    = 1'b1;
            rise_steps_next        = '0;
          end else begin
            peak_pending_next = 1'b0;
            fall_steps_next   = '0;
          end
          run_mode_next = RUN_RISE;
        end else if (run_mode_next == RUN_NONE) begin
          if (f > previous_sample_next) begin
            run_mode_next = RUN_RISE;
          end else if (f < previous_sample_next) begin
            run_mode_next = RUN_FALL;
          end
        end

        if ((run_mode_next == RUN_RISE) && valley_pending_next) begin
          rise_steps_next = rise_steps_next + 4'd1;
          if (rise_steps_next == cfg.confirm_steps) begin
            if (valley_count_next != 4'd15) begin
              valley_count_next = valley_count_next + 4'd1;
            end
            valley_pending_next = 1'b0;
            rise_steps_next     = '0;
            ev                  = EV_VALLEY;
            xval                = valley_cand_value_next;
            xidx                = valley_cand_index_next;
          end
        end else if ((run_mode_next == RUN_FALL) && peak_pending_next) begin
          fall_steps_next = fall_steps_next + 4'd1;
          if (fall_steps_next == cfg.confirm_steps) begin
            if (peak_count_next != 4'd15) begin
              peak_count_next = peak_count_next + 4'd1;
            end
            peak_pending_next = 1'b0;
            fall_steps_next   = '0;
            ev                = EV_PEAK;
            xval              = peak_cand_value_next;
            xidx              = peak_cand_index_next;
          end
        end
      end
      previous_sample_next = f;
      sample_count_next    = sample_count_next + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample   <= '0;
      sample_count      <= '0;
      run_mode          <= RUN_NONE;
      peak_pending      <= 1'b0;
      valley_pending    <= 1'b0;
      fall_steps        <= '0;
      rise_steps        <= '0;
      peak_cand_value   <= '0;
      peak_cand_index   <= '0;
      valley_cand_value <= '0;
      valley_cand_index <= '0;
      peak_count        <= '0;
      valley_count      <= '0;
    end else if (step) begin
      previous_sample   <= previous_sample_next;
      sample_count      <= sample_count_next;
      run_mode          <= run_mode_next;
      peak_pending      <= peak_pending_next;
      valley_pending    <= valley_pending_next;
      fall_steps        <= fall_steps_next;
      rise_steps        <= rise_steps_next;
      peak_cand_value   <= peak_cand_value_next;
      peak_cand_index   <= peak_cand_index_next;
      valley_cand_value <= valley_cand_value_next;
      valley_cand_index <= valley_cand_index_next;
      peak_count        <= peak_count_next;
      valley_count      <= valley_count_next;
    end
  end

  assign res.filtered_sample = f;
  assign res.event_res       = ev;
  assign res.extreme_value   = xval;
  assign res.extreme_index   = xidx;
  assign res.peak_total      = peak_count_next;
  assign res.valley_total    = valley_count_next;

endmodule

// File: test/tb_scan_peak_valley_detector.sv
// Self-checking testbench for scan_peak_valley_detector: a directed table, then random scans
// under several register settings, with random idling and stalls on both word channels.
// Depends on spvd_pkg and the detector RTL; results are predicted by a model kept in this file.
module tb_scan_peak_valley_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import spvd_pkg::*;

  localparam int SCAN_LEN = 256;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {SLOPE_FLAT = 2'd0, SLOPE_UP = 2'd1, SLOPE_DOWN = 2'd2} slope_t;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               st;
    logic               pinned;
    result_t            want;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] sample = '0;
  logic               scan_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] filtered_sample;
  logic [1:0]         event_res;
  logic signed [15:0] extreme_value;
  logic [7:0]         extreme_index;
  logic [3:0]         peak_total;
  logic [3:0]         valley_total;

  scan_peak_valley_detector #(.SCAN_LENGTH(SCAN_LEN)) dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .sample, .scan_start,
    .out_valid, .out_ready, .filtered_sample, .event_res, .extreme_value,
    .extreme_index, .peak_total, .valley_total
  );

  result_t expected_words[$];
  int      errors = 0;
  int      words_out = 0;
  bit      calm = 1'b0;

  logic [14:0] cfg_max_dist = MAX_DISTANCE_RESET;
  logic [7:0]  cfg_guard = GUARD_SAMPLES_RESET;
  logic [3:0]  cfg_confirm = CONFIRM_STEPS_RESET;

  logic signed [15:0] last_filt;
  int                 scan_pos;
  slope_t             slope;
  bit                 peak_armed, valley_armed;
  logic [3:0]         down_steps, up_steps;
  logic signed [15:0] peak_val, valley_val;
  logic [7:0]         peak_pos, valley_pos;
  logic [3:0]         peaks_seen, valleys_seen;

  probe_t probes [0:18] = '{
    '{16'sd100,  1'b1, 1'b1, '{16'sd100, EV_NONE, 16'sd0, 8'd0, 4'd0, 4'd0}},
    '{16'h8000,  1'b0, 1'b1, '{16'h8000, EV_NONE, 16'sd0, 8'd0, 4'd0, 4'd0}},
    '{16'sd32767, 1'b0, 1'b0, '0},
    '{16'sd32767, 1'b0, 1'b1, '{16'sd32767, EV_VALLEY, 16'h8000, 8'd1, 4'd0, 4'd1}},
    '{16'sd200,  1'b0, 1'b0, '0},
    '{16'sd150,  1'b0, 1'b1, '{16'sd150, EV_PEAK, 16'sd32767, 8'd3, 4'd1, 4'd1}},
    '{16'hFFFF,  1'b0, 1'b1, '{16'sd150, EV_NONE, 16'sd0, 8'd0, 4'd1, 4'd1}},
    '{16'sd346,  1'b0, 1'b1, '{16'sd150, EV_NONE, 16'sd0, 8'd0, 4'd1, 4'd1}},
    '{16'sd345,  1'b0, 1'b0, '0},
    '{16'sd300,  1'b0, 1'b0, '0},
    '{16'sd340,  1'b0, 1'b0, '0},
    '{16'sd341,  1'b0, 1'b0, '0},
    '{16'sd0,    1'b0, 1'b0, '0},
    '{16'sd10,   1'b0, 1'b0, '0},
    '{16'sd5,    1'b0, 1'b0, '0},
    '{16'sd5,    1'b0, 1'b0, '0},
    '{16'sd7,    1'b1, 1'b1, '{16'sd7, EV_NONE, 16'sd0, 8'd0, 4'd0, 4'd0}},
    '{16'hFFFB,  1'b1, 1'b1, '{16'hFFFB, EV_NONE, 16'sd0, 8'd0, 4'd0, 4'd0}},
    '{16'sd32767, 1'b0, 1'b0, '0}
  };

  function automatic void clear_scan();
    last_filt = '0;
    scan_pos = 0;
    slope = SLOPE_FLAT;
    peak_armed = 1'b0;
    valley_armed = 1'b0;
    down_steps = '0;
    up_steps = '0;
    peak_val = '0;
    peak_pos = '0;
    valley_val = '0;
    valley_pos = '0;
    peaks_seen = '0;
    valleys_seen = '0;
  endfunction

  function automatic logic [1:0] rise_tick();
    if (valley_armed) begin
      up_steps = up_steps + 4'd1;
      if (up_steps == cfg_confirm) begin
        if (valleys_seen != 4'd15) valleys_seen = valleys_seen + 4'd1;
        valley_armed = 1'b0;
        up_steps = '0;
        return EV_VALLEY;
      end
    end
    return EV_NONE;
  endfunction

  function automatic logic [1:0] fall_tick();
    if (peak_armed) begin
      down_steps = down_steps + 4'd1;
      if (down_steps == cfg_confirm) begin
        if (peaks_seen != 4'd15) peaks_seen = peaks_seen + 4'd1;
        peak_armed = 1'b0;
        down_steps = '0;
        return EV_PEAK;
      end
    end
    return EV_NONE;
  endfunction

  function automatic result_t detect_step(input logic signed [15:0] raw, input logic st);
    result_t r;
    int k;
    int f;
    int d;
    logic [1:0] ev;
    r = '0;
    ev = EV_NONE;
    if (st) clear_scan();
    k = scan_pos;
    f = raw;
    if (k > int'(cfg_guard) && (f < 0 || f > int'(cfg_max_dist))) f = last_filt;
    if (k < SCAN_LEN) begin
      if (k > 0) begin
        d = f - int'(last_filt);
        if (slope == SLOPE_UP && d < 0) begin
          if (!valley_armed) begin
            peak_val = last_filt;
            peak_pos = 8'(k - 1);
            peak_armed = 1'b1;
          end else begin
            peak_armed = 1'b0;
          end
          down_steps = '0;
          slope = SLOPE_DOWN;
        end else if (slope == SLOPE_DOWN && d > 0) begin
          if (!peak_armed) begin
            valley_val = last_filt;
            valley_pos = 8'(k - 1);
            valley_armed = 1'b1;
            up_steps = '0;
          end else begin
            peak_armed = 1'b0;
            down_steps = '0;
          end
          slope = SLOPE_UP;
        end else if (slope == SLOPE_FLAT) begin
          if (d > 0) slope = SLOPE_UP;
          else if (d < 0) slope = SLOPE_DOWN;
        end
        if (slope == SLOPE_UP) ev = rise_tick();
        else if (slope == SLOPE_DOWN) ev = fall_tick();
        if (ev == EV_PEAK) begin
          r.extreme_value = peak_val;
          r.extreme_index = peak_pos;
        end else if (ev == EV_VALLEY) begin
          r.extreme_value = valley_val;
          r.extreme_index = valley_pos;
        end
      end
      last_filt = f[15:0];
      scan_pos = k + 1;
    end
    r.filtered_sample = f[15:0];
    r.event_res = ev;
    r.peak_total = peaks_seen;
    r.valley_total = valleys_seen;
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb_scan_peak_valley_detector: FAIL");
    $finish;
  end

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input logic signed [15:0] s, input logic st,
                           input bit pinned, input result_t want);
    int gap;
    result_t pred;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    scan_start <= st;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pred = detect_step(s, st);
    expected_words.push_back(pinned ? want : pred);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      REG_MAX_DISTANCE:  cfg_max_dist = data;
      REG_GUARD_SAMPLES: cfg_guard = data[7:0];
      REG_CONFIRM_STEPS: cfg_confirm = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [14:0] maxd, input logic [7:0] guard,
                          input logic [3:0] confirm);
    write_reg(REG_MAX_DISTANCE, maxd);
    write_reg(REG_GUARD_SAMPLES, {7'($urandom()), guard});
    write_reg(REG_CONFIRM_STEPS, {11'($urandom()), confirm});
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Each scan is a random walk over the legal range made of rising and falling
  // runs, with equal samples, out-of-range noise and the odd early restart.
  task automatic run_scans(input int budget, input bit long_scans);
    int sent;
    int len;
    int seg_left;
    int stepmax;
    int span;
    int step;
    int cur;
    bit up;
    bit first;
    logic signed [15:0] s;
    logic st;
    span = int'(cfg_max_dist);
    stepmax = (span / 8 < 1) ? 1 : span / 8;
    sent = 0;
    first = long_scans;
    while (sent < budget) begin
      if (long_scans && (first || $urandom_range(0, 11) == 0)) len = $urandom_range(257, 300);
      else len = $urandom_range(2, 60);
      first = 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      cur = $urandom_range(0, span);
      seg_left = 0;
      for (int i = 0; i < len; i++) begin
        if (seg_left == 0) begin
          up = 1'($urandom_range(0, 1));
          seg_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        end
        seg_left--;
        step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, stepmax);
        cur = up ? cur + step : cur - step;
        if (cur < 0) cur = 0;
        if (cur > span) cur = span;
        s = cur[15:0];
        if ($urandom_range(0, 11) == 0) s = 16'($urandom());
        st = (i == 0) || ($urandom_range(0, 49) == 0);
        send_word(s, st, 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  task automatic check_word(input result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: result word with nothing expected: %p", $time, got);
      errors++;
    end else begin
      want = expected_words.pop_front();
      if (got.filtered_sample !== want.filtered_sample) begin
        $display("%0t: filtered_sample expected %0d got %0d", $time,
                 want.filtered_sample, got.filtered_sample);
        errors++;
      end
      if (got.event_res !== want.event_res) begin
        $display("%0t: event_res expected %0d got %0d", $time, want.event_res, got.event_res);
        errors++;
      end
      if (got.extreme_value !== want.extreme_value) begin
        $display("%0t: extreme_value expected %0d got %0d", $time,
                 want.extreme_value, got.extreme_value);
        errors++;
      end
      if (got.extreme_index !== want.extreme_index) begin
        $display("%0t: extreme_index expected %0d got %0d", $time,
                 want.extreme_index, got.extreme_index);
        errors++;
      end
      if (got.peak_total !== want.peak_total) begin
        $display("%0t: peak_total expected %0d got %0d", $time, want.peak_total, got.peak_total);
        errors++;
      end
      if (got.valley_total !== want.valley_total) begin
        $display("%0t: valley_total expected %0d got %0d", $time,
                 want.valley_total, got.valley_total);
        errors++;
      end
    end
  endtask

  // Result side. Twice in the run it holds off long enough for the block to
  // fill up and push back on its input.
  initial begin
    int stall;
    result_t got;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got.filtered_sample = filtered_sample;
      got.event_res = event_res;
      got.extreme_value = extreme_value;
      got.extreme_index = extreme_index;
      got.peak_total = peak_total;
      got.valley_total = valley_total;
      check_word(got);
      @(posedge clk);
      words_out++;
      if (words_out == 60 || words_out == 400) begin
        out_ready <= 1'b0;
        repeat (40) @(posedge clk);
      end
    end
  end

  initial begin
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) send_word(probes[i].smp, probes[i].st, probes[i].pinned, probes[i].want);
    settle();

    set_regs(15'd32767, 8'd0, 4'd1);
    run_scans(100, 1'b0);
    settle();

    set_regs(15'd0, 8'd255, 4'd15);
    run_scans(200, 1'b1);
    settle();

    set_regs(15'($urandom_range(100, 2000)), 8'($urandom_range(0, 10)), 4'd0);
    run_scans(200, 1'b1);
    settle();

    write_reg(REG_UNUSED, 15'($urandom()));
    set_regs(15'($urandom()), 8'($urandom_range(0, 20)), 4'($urandom_range(1, 15)));
    run_scans(60, 1'b0);
    settle();

    set_regs(MAX_DISTANCE_RESET, GUARD_SAMPLES_RESET, CONFIRM_STEPS_RESET);
    run_scans(40, 1'b0);
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_scan_peak_valley_detector: PASS");
    end else begin
      $display("tb_scan_peak_valley_detector: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/spvd_pkg.sv
hw/rtl/spvd_cfg.sv
hw/rtl/spvd_core.sv
hw/rtl/scan_peak_valley_detector.sv
test/tb_scan_peak_valley_detector.sv
